/* design/x509_der_field_locator_assert.svh */
// Assertion macros for the X.509 DER field locator.
// Included by the top level; needs clk and rst in the including scope.
`ifndef X509_DER_FIELD_LOCATOR_ASSERT_SVH
`define X509_DER_FIELD_LOCATOR_ASSERT_SVH

`ifndef SYNTH
`define X509_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("x509 locator check failed");
`define X509_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("x509 locator check failed");
`else
`define X509_ASSERT_NOW(label, ante, cons)
`define X509_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/x509dfl_pkg.sv */
// Shared types and codes for the X.509 DER field locator.
// No dependencies; used by x509dfl_core and x509_der_field_locator.
`timescale 1ns / 1ps

package x509dfl_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int POS_W       = OFFSET_BITS + 1;

  // parse phase codes
  localparam logic [4:0] PH_CERT      = 5'd0;
  localparam logic [4:0] PH_TBS       = 5'd1;
  localparam logic [4:0] PH_VER_OR_SN = 5'd2;
  localparam logic [4:0] PH_VERSION   = 5'd3;
  localparam logic [4:0] PH_SERIAL    = 5'd4;
  localparam logic [4:0] PH_TBSALG    = 5'd5;
  localparam logic [4:0] PH_ISSUER    = 5'd6;
  localparam logic [4:0] PH_VALIDITY  = 5'd7;
  localparam logic [4:0] PH_NOTBEFORE = 5'd8;
  localparam logic [4:0] PH_NOTAFTER  = 5'd9;
  localparam logic [4:0] PH_SUBJECT   = 5'd10;
  localparam logic [4:0] PH_PUBKEY    = 5'd11;
  localparam logic [4:0] PH_OPT1      = 5'd12;
  localparam logic [4:0] PH_OPT2      = 5'd13;
  localparam logic [4:0] PH_OPT3      = 5'd14;
  localparam logic [4:0] PH_SIGALG    = 5'd15;
  localparam logic [4:0] PH_SIGVAL    = 5'd16;
  localparam logic [4:0] PH_DONE      = 5'd17;

  // header stage codes
  localparam logic [1:0] ST_TAG  = 2'd0;
  localparam logic [1:0] ST_LEN1 = 2'd1;
  localparam logic [1:0] ST_LENX = 2'd2;
  localparam logic [1:0] ST_SKIP = 2'd3;

  // field kinds; the version wrapper is internal only
  localparam logic [4:0] K_CERT     = 5'd0;
  localparam logic [4:0] K_TBS      = 5'd1;
  localparam logic [4:0] K_VERSION  = 5'd2;
  localparam logic [4:0] K_SERIAL   = 5'd3;
  localparam logic [4:0] K_TBSALG   = 5'd4;
  localparam logic [4:0] K_ISSUER   = 5'd5;
  localparam logic [4:0] K_VALIDITY = 5'd6;
  localparam logic [4:0] K_NOTBEF   = 5'd7;
  localparam logic [4:0] K_NOTAFT   = 5'd8;
  localparam logic [4:0] K_SUBJECT  = 5'd9;
  localparam logic [4:0] K_PUBKEY   = 5'd10;
  localparam logic [4:0] K_ISSUID   = 5'd11;
  localparam logic [4:0] K_SUBUID   = 5'd12;
  localparam logic [4:0] K_EXTS     = 5'd13;
  localparam logic [4:0] K_SIGALG   = 5'd14;
  localparam logic [4:0] K_SIGVAL   = 5'd15;
  localparam logic [4:0] K_WRAP     = 5'd16;

  localparam logic [7:0] TAG_CTX0 = 8'hA0;
  localparam logic [7:0] TAG_CTX1 = 8'hA1;
  localparam logic [7:0] TAG_CTX2 = 8'hA2;
  localparam logic [7:0] TAG_CTX3 = 8'hA3;

  typedef struct packed {
    logic [4:0]             phase;
    logic [1:0]             stage;
    logic [POS_W-1:0]       pos;
    logic [3:0]             len_left;
    logic [OFFSET_BITS-1:0] len_acc;
    logic [OFFSET_BITS-1:0] skip;
    logic [OFFSET_BITS-1:0] tbs_end;
    logic [OFFSET_BITS-1:0] field_start;
    logic [4:0]             kind;
    logic                   halted;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase: PH_CERT, stage: ST_TAG, pos: '0, len_left: '0, len_acc: '0,
    skip: '0, tbs_end: '0, field_start: '0, kind: K_CERT, halted: 1'b0
  };

  typedef struct packed {
    logic                   vld;
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] doff;
    logic [OFFSET_BITS-1:0] dlen;
    logic [OFFSET_BITS-1:0] voff;
    logic [OFFSET_BITS-1:0] vlen;
    logic                   status;
    logic                   fin;
  } result_t;

endpackage

/* design/x509dfl_core.sv */
// Per-byte next-state and result logic of the X.509 DER field locator.
// Depends on x509dfl_pkg.
`timescale 1ns / 1ps

module x509dfl_core import x509dfl_pkg::*; (
  input  parse_t     cur,
  input  logic [7:0] byte_value,
  input  logic       first,
  output parse_t     nxt,
  output result_t    res
);

  function automatic logic [4:0] resolve(input logic [4:0] ph, input logic [7:0] b,
                                         input logic in_tbs);
    logic [4:0] k;
    k = K_SIGVAL;
    unique case (ph)
      PH_CERT:      k = K_CERT;
      PH_TBS:       k = K_TBS;
      PH_VER_OR_SN: k = (b == TAG_CTX0) ? K_WRAP : K_SERIAL;
      PH_VERSION:   k = K_VERSION;
      PH_SERIAL:    k = K_SERIAL;
      PH_TBSALG:    k = K_TBSALG;
      PH_ISSUER:    k = K_ISSUER;
      PH_VALIDITY:  k = K_VALIDITY;
      PH_NOTBEFORE: k = K_NOTBEF;
      PH_NOTAFTER:  k = K_NOTAFT;
      PH_SUBJECT:   k = K_SUBJECT;
      PH_PUBKEY:    k = K_PUBKEY;
      PH_OPT1: begin
        priority if (in_tbs && b == TAG_CTX1) k = K_ISSUID;
        else if (in_tbs && b == TAG_CTX2) k = K_SUBUID;
        else if (in_tbs && b == TAG_CTX3) k = K_EXTS;
        else k = K_SIGALG;
      end
      PH_OPT2: begin
        priority if (in_tbs && b == TAG_CTX2) k = K_SUBUID;
        else if (in_tbs && b == TAG_CTX3) k = K_EXTS;
        else k = K_SIGALG;
      end
      PH_OPT3:      k = (in_tbs && b == TAG_CTX3) ? K_EXTS : K_SIGALG;
      PH_SIGALG:    k = K_SIGALG;
      default:      k = K_SIGVAL;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] phase_after(input logic [4:0] k);
    logic [4:0] p;
    p = PH_DONE;
    unique case (k)
      K_CERT:     p = PH_TBS;
      K_TBS:      p = PH_VER_OR_SN;
      K_WRAP:     p = PH_VERSION;
      K_VERSION:  p = PH_SERIAL;
      K_SERIAL:   p = PH_TBSALG;
      K_TBSALG:   p = PH_ISSUER;
      K_ISSUER:   p = PH_VALIDITY;
      K_VALIDITY: p = PH_NOTBEFORE;
      K_NOTBEF:   p = PH_NOTAFTER;
      K_NOTAFT:   p = PH_SUBJECT;
      K_SUBJECT:  p = PH_PUBKEY;
      K_PUBKEY:   p = PH_OPT1;
      K_ISSUID:   p = PH_OPT2;
      K_SUBUID:   p = PH_OPT3;
      K_EXTS:     p = PH_SIGALG;
      K_SIGALG:   p = PH_SIGVAL;
      default:    p = PH_DONE;
    endcase
    return p;
  endfunction

  parse_t                 s;
  logic                   active;
  logic                   in_tbs;
  logic [4:0]             kind_now;
  logic [OFFSET_BITS-1:0] start_now;
  logic                   do_fin;
  logic                   do_fail;
  logic [OFFSET_BITS-1:0] fin_len;
  logic [OFFSET_BITS+7:0] acc_wide;
  logic [3:0]             left_dec;
  logic [OFFSET_BITS-1:0] skip_dec;
  logic [POS_W-1:0]       voff;
  logic [POS_W:0]         vend;
  logic                   descend;

  always_comb begin
    s         = first ? PARSE_RESET : cur;
    nxt       = s;
    res       = '0;
    active    = !s.halted && (s.phase != PH_DONE);
    in_tbs    = s.pos < {1'b0, s.tbs_end};
    kind_now  = s.kind;
    start_now = s.field_start;
    do_fin    = 1'b0;
    do_fail   = 1'b0;
    fin_len   = '0;
    acc_wide  = {s.len_acc, byte_value};
    left_dec  = s.len_left - 4'd1;
    skip_dec  = s.skip - OFFSET_BITS'(1);
    voff      = s.pos + POS_W'(1);
    descend   = 1'b0;

    if (active) begin
      nxt.pos = s.pos + POS_W'(1);
      unique case (s.stage)
        ST_TAG: begin
          kind_now        = resolve(s.phase, byte_value, in_tbs);
          start_now       = s.pos[OFFSET_BITS-1:0];
          nxt.kind        = kind_now;
          nxt.field_start = start_now;
          if (s.pos[POS_W-1]) do_fail = 1'b1;
          else nxt.stage = ST_LEN1;
        end
        ST_LEN1: begin
          if (s.pos[POS_W-1]) begin
            do_fail = 1'b1;
          end else if (byte_value[7]) begin
            nxt.len_left = byte_value[3:0];
            nxt.len_acc  = '0;
            if (byte_value[3:0] == 4'd0) do_fin = 1'b1;
            else nxt.stage = ST_LENX;
          end else begin
            do_fin  = 1'b1;
            fin_len = OFFSET_BITS'(byte_value[6:0]);
          end
        end
        ST_LENX: begin
          if (s.pos[POS_W-1] || (acc_wide[OFFSET_BITS+7:OFFSET_BITS] != 8'd0)) begin
            do_fail = 1'b1;
          end else begin
            nxt.len_acc  = acc_wide[OFFSET_BITS-1:0];
            nxt.len_left = left_dec;
            fin_len      = acc_wide[OFFSET_BITS-1:0];
            do_fin       = (left_dec == 4'd0);
          end
        end
        default: begin
          nxt.skip = (s.skip != '0) ? skip_dec : s.skip;
          if (s.skip <= OFFSET_BITS'(1)) nxt.stage = ST_TAG;
        end
      endcase
    end

    vend = {1'b0, voff} + (POS_W + 1)'(fin_len);
    if (do_fin && (vend[POS_W:OFFSET_BITS] != '0)) begin
      do_fail = 1'b1;
      do_fin  = 1'b0;
    end

    if (do_fail) begin
      nxt.halted = 1'b1;
      res.vld    = 1'b1;
      res.kind   = (kind_now == K_WRAP) ? K_VERSION[3:0] : kind_now[3:0];
      res.doff   = start_now;
      res.status = 1'b1;
      res.fin    = 1'b1;
    end else if (do_fin) begin
      nxt.phase = phase_after(kind_now);
      descend   = (kind_now == K_CERT) || (kind_now == K_TBS) ||
                  (kind_now == K_WRAP) || (kind_now == K_VALIDITY);
      if (kind_now == K_TBS) nxt.tbs_end = vend[OFFSET_BITS-1:0];
      if (!descend && (fin_len != '0) && (kind_now != K_SIGVAL)) begin
        nxt.skip  = fin_len;
        nxt.stage = ST_SKIP;
      end else begin
        nxt.stage = ST_TAG;
      end
      if (kind_now != K_WRAP) begin
        res.vld  = 1'b1;
        res.kind = kind_now[3:0];
        res.doff = start_now;
        res.dlen = vend[OFFSET_BITS-1:0] - start_now;
        res.voff = voff[OFFSET_BITS-1:0];
        res.vlen = fin_len;
        res.fin  = (kind_now == K_SIGVAL);
      end
    end
  end

endmodule

/* design/x509_der_field_locator.sv */
// Top level of the X.509 DER field locator: input register, parse state, result register.
// Depends on x509dfl_pkg, x509dfl_core and x509_der_field_locator_assert.svh.
`timescale 1ns / 1ps

// Streams a DER certificate one byte per item and reports, for each known field, the
// offset and length of the whole element and of its value. An item with first set
// restarts the parse at offset 0. One byte is taken per cycle with no stalls of its own
// while the output is not held; a byte's result, if any, goes from the input register
// through the header and length logic into the result register, from which it is offered.
// A length that does not fit 16-bit offsets yields one error result and
// the block drops bytes until the next first; after the signature value all bytes
// are dropped likewise.
module x509_der_field_locator import x509dfl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             byte_value,
  input  logic                   first,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             field_kind,
  output logic [OFFSET_BITS-1:0] data_offset,
  output logic [OFFSET_BITS-1:0] data_length,
  output logic [OFFSET_BITS-1:0] value_offset,
  output logic [OFFSET_BITS-1:0] value_length,
  output logic                   status,
  output logic                   final_res
);

  `include "x509_der_field_locator_assert.svh"

  logic       s1_vld;
  logic [7:0] s1_byte;
  logic       s1_first;
  parse_t     st;
  parse_t     st_next;
  result_t    res;
  result_t    out_q;
  logic       out_vld;
  logic       out_free;
  logic       proc;

  assign out_free = !out_vld || out_ready;
  assign proc     = s1_vld && out_free;
  assign in_ready = !s1_vld || out_free;

  x509dfl_core u_core (
    .cur        (st),
    .byte_value (s1_byte),
    .first      (s1_first),
    .nxt        (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
      st      <= PARSE_RESET;
    end else begin
      if (in_ready) s1_vld <= in_valid;
      if (proc) st <= st_next;
      if (out_free) out_vld <= proc && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= byte_value;
      s1_first <= first;
    end
    if (proc && res.vld) out_q <= res;
  end

  assign out_valid    = out_vld;
  assign field_kind   = out_q.kind;
  assign data_offset  = out_q.doff;
  assign data_length  = out_q.dlen;
  assign value_offset = out_q.voff;
  assign value_length = out_q.vlen;
  assign status       = out_q.status;
  assign final_res    = out_q.fin;

  `X509_ASSERT_NEXT(a_fail_halts, proc && res.vld && res.status, st.halted)
  `X509_ASSERT_NEXT(a_stopped_frozen, proc && !s1_first && (st.halted || st.phase == PH_DONE), $stable(st))
  `X509_ASSERT_NOW(a_skip_nonzero, st.stage == ST_SKIP && !st.halted, st.skip != '0)
  `X509_ASSERT_NEXT(a_no_out_when_stopped, proc && !s1_first && st.halted && out_ready, !out_valid)

endmodule

/* sim/der_field_check.sv */
`timescale 1ns / 1ps
// Checker for the X.509 DER field locator: watches both item channels, predicts the
// field descriptor each accepted byte produces and compares it with each returned item.
// Depends on x509dfl_pkg for the offset width and the phase, stage and kind codes.

module der_field_check import x509dfl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             byte_value,
  input  logic                   first,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [3:0]             field_kind,
  input  logic [OFFSET_BITS-1:0] data_offset,
  input  logic [OFFSET_BITS-1:0] data_length,
  input  logic [OFFSET_BITS-1:0] value_offset,
  input  logic [OFFSET_BITS-1:0] value_length,
  input  logic                   status,
  input  logic                   final_res,
  output int                     mismatches,
  output int                     outstanding
);

  localparam logic [31:0] POS_MAX = (32'd1 << OFFSET_BITS) - 32'd1;

  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] doff;
    logic [OFFSET_BITS-1:0] dlen;
    logic [OFFSET_BITS-1:0] voff;
    logic [OFFSET_BITS-1:0] vlen;
    logic                   bad;
    logic                   fin;
  } field_loc_t;

  field_loc_t  pending_fields[$];
  field_loc_t  want;

  logic [4:0]  phase;
  logic [1:0]  hstage;
  logic [31:0] pos;
  logic [3:0]  len_left;
  logic [31:0] len_acc;
  logic [31:0] skip_left;
  logic [31:0] tbs_limit;
  logic [31:0] tag_at;
  logic [4:0]  cur_kind;
  logic        stopped;

  task automatic restart_parse();
    phase     = PH_CERT;
    hstage    = ST_TAG;
    pos       = '0;
    len_left  = '0;
    len_acc   = '0;
    skip_left = '0;
    tbs_limit = '0;
    tag_at    = '0;
    cur_kind  = K_CERT;
    stopped   = 1'b0;
  endtask

  task automatic report(input logic [4:0] kind, input logic [31:0] doff, input logic [31:0] dlen,
                        input logic [31:0] voff, input logic [31:0] vlen, input logic bad,
                        input logic fin);
    field_loc_t rec;
    rec.kind = kind[3:0];
    rec.doff = doff[OFFSET_BITS-1:0];
    rec.dlen = dlen[OFFSET_BITS-1:0];
    rec.voff = voff[OFFSET_BITS-1:0];
    rec.vlen = vlen[OFFSET_BITS-1:0];
    rec.bad  = bad;
    rec.fin  = fin;
    pending_fields.push_back(rec);
  endtask

  task automatic halt_parse();
    stopped = 1'b1;
    report((cur_kind == K_WRAP) ? K_VERSION : cur_kind, tag_at, '0, '0, '0, 1'b1, 1'b1);
  endtask

  function automatic logic [4:0] classify(input logic [7:0] b);
    logic in_tbs;
    in_tbs = pos < tbs_limit;
    case (phase)
      PH_CERT:      return K_CERT;
      PH_TBS:       return K_TBS;
      PH_VER_OR_SN: return (b == TAG_CTX0) ? K_WRAP : K_SERIAL;
      PH_VERSION:   return K_VERSION;
      PH_SERIAL:    return K_SERIAL;
      PH_TBSALG:    return K_TBSALG;
      PH_ISSUER:    return K_ISSUER;
      PH_VALIDITY:  return K_VALIDITY;
      PH_NOTBEFORE: return K_NOTBEF;
      PH_NOTAFTER:  return K_NOTAFT;
      PH_SUBJECT:   return K_SUBJECT;
      PH_PUBKEY:    return K_PUBKEY;
      PH_OPT1: begin
        if (in_tbs && b == TAG_CTX1) return K_ISSUID;
        if (in_tbs && b == TAG_CTX2) return K_SUBUID;
        if (in_tbs && b == TAG_CTX3) return K_EXTS;
        return K_SIGALG;
      end
      PH_OPT2: begin
        if (in_tbs && b == TAG_CTX2) return K_SUBUID;
        if (in_tbs && b == TAG_CTX3) return K_EXTS;
        return K_SIGALG;
      end
      PH_OPT3: begin
        if (in_tbs && b == TAG_CTX3) return K_EXTS;
        return K_SIGALG;
      end
      PH_SIGALG:    return K_SIGALG;
      default:      return K_SIGVAL;
    endcase
  endfunction

  task automatic close_header(input logic [31:0] len);
    logic [31:0] voff;
    logic        descend;
    voff    = pos + 32'd1;
    descend = 1'b0;
    if (voff + len > POS_MAX) begin
      halt_parse();
      return;
    end
    case (cur_kind)
      K_CERT: begin
        phase   = PH_TBS;
        descend = 1'b1;
      end
      K_TBS: begin
        phase     = PH_VER_OR_SN;
        descend   = 1'b1;
        tbs_limit = voff + len;
      end
      K_WRAP: begin
        phase   = PH_VERSION;
        descend = 1'b1;
      end
      K_VALIDITY: begin
        phase   = PH_NOTBEFORE;
        descend = 1'b1;
      end
      K_VERSION:  phase = PH_SERIAL;
      K_SERIAL:   phase = PH_TBSALG;
      K_TBSALG:   phase = PH_ISSUER;
      K_ISSUER:   phase = PH_VALIDITY;
      K_NOTBEF:   phase = PH_NOTAFTER;
      K_NOTAFT:   phase = PH_SUBJECT;
      K_SUBJECT:  phase = PH_PUBKEY;
      K_PUBKEY:   phase = PH_OPT1;
      K_ISSUID:   phase = PH_OPT2;
      K_SUBUID:   phase = PH_OPT3;
      K_EXTS:     phase = PH_SIGALG;
      K_SIGALG:   phase = PH_SIGVAL;
      default:    phase = PH_DONE;
    endcase
    if (!descend && len != 0 && phase != PH_DONE) begin
      skip_left = len;
      hstage    = ST_SKIP;
    end else begin
      hstage = ST_TAG;
    end
    if (cur_kind != K_WRAP) begin
      report(cur_kind, tag_at, voff - tag_at + len, voff, len, 1'b0, cur_kind == K_SIGVAL);
    end
  endtask

  task automatic locate_byte(input logic [7:0] b, input logic restart);
    if (restart) restart_parse();
    if (stopped || phase == PH_DONE) return;
    case (hstage)
      ST_TAG: begin
        cur_kind = classify(b);
        tag_at   = pos;
        if (pos > POS_MAX) begin
          halt_parse();
          return;
        end
        hstage = ST_LEN1;
      end
      ST_LEN1: begin
        if (pos > POS_MAX) begin
          halt_parse();
          return;
        end
        if (b[7]) begin
          len_left = b[3:0];
          len_acc  = '0;
          if (len_left == 0) close_header('0);
          else hstage = ST_LENX;
        end else begin
          close_header({24'd0, b});
        end
      end
      ST_LENX: begin
        if (pos > POS_MAX) begin
          halt_parse();
          return;
        end
        len_acc = (len_acc << 8) | {24'd0, b};
        if (len_acc > POS_MAX) begin
          halt_parse();
          return;
        end
        len_left = len_left - 4'd1;
        if (len_left == 0) close_header(len_acc);
      end
      default: begin
        if (skip_left != 0) skip_left = skip_left - 32'd1;
        if (skip_left == 0) hstage = ST_TAG;
      end
    endcase
    pos = pos + 32'd1;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s expected %0d got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      pending_fields.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_fields.size() == 0) begin
          $error("field item with none pending: kind %0d offset %0d", field_kind, data_offset);
          mismatches++;
        end else begin
          want = pending_fields.pop_front();
          check_field("field_kind", want.kind, field_kind);
          check_field("data_offset", want.doff, data_offset);
          check_field("data_length", want.dlen, data_length);
          check_field("value_offset", want.voff, value_offset);
          check_field("value_length", want.vlen, value_length);
          check_field("status", want.bad, status);
          check_field("final_res", want.fin, final_res);
        end
      end
      if (in_valid && in_ready) locate_byte(byte_value, first);
    end
    outstanding = pending_fields.size();
  end

endmodule

/* sim/tb_x509_der_field_locator.sv */
`timescale 1ns / 1ps
// Testbench top for the X.509 DER field locator: drives certificate byte streams,
// random receiver stalls and a watchdog, and prints the verdict.
// Depends on x509dfl_pkg, the block itself and the der_field_check checker.

module tb_x509_der_field_locator;
  import x509dfl_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 8;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             byte_value;
  logic                   first;
  logic                   out_valid;
  logic                   out_ready;
  logic [3:0]             field_kind;
  logic [OFFSET_BITS-1:0] data_offset;
  logic [OFFSET_BITS-1:0] data_length;
  logic [OFFSET_BITS-1:0] value_offset;
  logic [OFFSET_BITS-1:0] value_length;
  logic                   status;
  logic                   final_res;
  int                     mismatches;
  int                     outstanding;

  logic [8:0] feed_q[$];
  int         tx_mode;
  int         useful;
  int         round_no;
  bit         hold_req;
  int         rx_drop;
  int         rx_run;
  int         idle_cycles;

  x509_der_field_locator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_value   (byte_value),
    .first        (first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_kind   (field_kind),
    .data_offset  (data_offset),
    .data_length  (data_length),
    .value_offset (value_offset),
    .value_length (value_length),
    .status       (status),
    .final_res    (final_res)
  );

  der_field_check chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_value   (byte_value),
    .first        (first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_kind   (field_kind),
    .data_offset  (data_offset),
    .data_length  (data_length),
    .value_offset (value_offset),
    .value_length (value_length),
    .status       (status),
    .final_res    (final_res),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_byte(input logic fst, input logic [7:0] b);
    feed_q.push_back({fst, b});
  endtask

  function automatic int len_bytes(input int len);
    if (len == 0) return 0;
    if (len < 256) return 1;
    return 2;
  endfunction

  function automatic int hdr_size(input int len, input int form);
    if (form == 0 && len < 128) return 2;
    return 2 + len_bytes(len) + ((form == 2) ? 1 : 0);
  endfunction

  function automatic int leaf_size(input int len, input int form);
    return hdr_size(len, form) + len;
  endfunction

  task automatic push_hdr(input logic fst, input logic [7:0] tag, input int len, input int form);
    int         n;
    logic [2:0] junk;
    logic [31:0] lv;
    push_byte(fst, tag);
    lv = len;
    if (form == 0 && len < 128) begin
      push_byte(1'b0, lv[7:0]);
    end else begin
      n    = len_bytes(len) + ((form == 2) ? 1 : 0);
      junk = ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, 7)) : 3'd0;
      push_byte(1'b0, {1'b1, junk, 4'(n)});
      for (int i = n - 1; i >= 0; i--) push_byte(1'b0, 8'(lv >> (8 * i)));
    end
  endtask

  task automatic push_leaf(input logic [7:0] tag, input int len, input int form);
    push_hdr(1'b0, tag, len, form);
    repeat (len) push_byte(1'b0, 8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 3);
    if (r < 98) return $urandom_range(4, 40);
    if (r == 98) return 127;
    return $urandom_range(128, 300);
  endfunction

  function automatic int pick_form();
    int r;
    r = $urandom_range(0, 5);
    if (r < 4) return 0;
    return r - 3;
  endfunction

  task automatic build_cert();
    int         lens[17];
    int         forms[17];
    logic [7:0] tags[17];
    bit         has_ver;
    bit         has_u1;
    bit         has_u2;
    bit         has_u3;
    int         wrap_body;
    int         val_body;
    int         tbs_body;
    int         tbs_decl;
    int         cert_body;
    int         start;
    start = feed_q.size();
    for (int k = 0; k < 17; k++) begin
      lens[k]  = pick_len();
      forms[k] = pick_form();
      tags[k]  = 8'h30;
    end
    tags[K_VERSION] = 8'h02;
    tags[K_SERIAL]  = 8'h02;
    tags[K_NOTBEF]  = 8'h17;
    tags[K_NOTAFT]  = 8'h18;
    tags[K_SIGVAL]  = 8'h03;
    for (int k = 0; k < 16; k++) begin
      if ($urandom_range(0, 9) == 0) tags[k] = 8'($urandom_range(0, 255));
    end
    tags[K_ISSUID] = TAG_CTX1;
    tags[K_SUBUID] = TAG_CTX2;
    tags[K_EXTS]   = TAG_CTX3;
    tags[K_WRAP]   = TAG_CTX0;
    lens[K_VERSION] = $urandom_range(1, 3);
    has_ver = ($urandom_range(0, 1) != 0);
    has_u1  = ($urandom_range(0, 1) != 0);
    has_u2  = ($urandom_range(0, 1) != 0);
    has_u3  = ($urandom_range(0, 1) != 0);

    wrap_body = leaf_size(lens[K_VERSION], forms[K_VERSION]);
    val_body  = leaf_size(lens[K_NOTBEF], forms[K_NOTBEF])
              + leaf_size(lens[K_NOTAFT], forms[K_NOTAFT]);
    tbs_body  = leaf_size(lens[K_SERIAL], forms[K_SERIAL])
              + leaf_size(lens[K_TBSALG], forms[K_TBSALG])
              + leaf_size(lens[K_ISSUER], forms[K_ISSUER])
              + hdr_size(val_body, forms[K_VALIDITY]) + val_body
              + leaf_size(lens[K_SUBJECT], forms[K_SUBJECT])
              + leaf_size(lens[K_PUBKEY], forms[K_PUBKEY]);
    if (has_ver) tbs_body += hdr_size(wrap_body, forms[K_WRAP]) + wrap_body;
    if (has_u1) tbs_body += leaf_size(lens[K_ISSUID], forms[K_ISSUID]);
    if (has_u2) tbs_body += leaf_size(lens[K_SUBUID], forms[K_SUBUID]);
    if (has_u3) tbs_body += leaf_size(lens[K_EXTS], forms[K_EXTS]);
    tbs_decl = tbs_body;
    if ($urandom_range(0, 9) == 0) tbs_decl = tbs_body + int'($urandom_range(0, 8)) - 4;
    if (tbs_decl < 0) tbs_decl = 0;
    cert_body = hdr_size(tbs_decl, forms[K_TBS]) + tbs_body
              + leaf_size(lens[K_SIGALG], forms[K_SIGALG])
              + leaf_size(lens[K_SIGVAL], forms[K_SIGVAL]);

    push_hdr(1'b1, tags[K_CERT], cert_body, forms[K_CERT]);
    push_hdr(1'b0, tags[K_TBS], tbs_decl, forms[K_TBS]);
    if (has_ver) begin
      push_hdr(1'b0, tags[K_WRAP], wrap_body, forms[K_WRAP]);
      push_leaf(tags[K_VERSION], lens[K_VERSION], forms[K_VERSION]);
    end
    push_leaf(tags[K_SERIAL], lens[K_SERIAL], forms[K_SERIAL]);
    push_leaf(tags[K_TBSALG], lens[K_TBSALG], forms[K_TBSALG]);
    push_leaf(tags[K_ISSUER], lens[K_ISSUER], forms[K_ISSUER]);
    push_hdr(1'b0, tags[K_VALIDITY], val_body, forms[K_VALIDITY]);
    push_leaf(tags[K_NOTBEF], lens[K_NOTBEF], forms[K_NOTBEF]);
    push_leaf(tags[K_NOTAFT], lens[K_NOTAFT], forms[K_NOTAFT]);
    push_leaf(tags[K_SUBJECT], lens[K_SUBJECT], forms[K_SUBJECT]);
    push_leaf(tags[K_PUBKEY], lens[K_PUBKEY], forms[K_PUBKEY]);
    if (has_u1) push_leaf(tags[K_ISSUID], lens[K_ISSUID], forms[K_ISSUID]);
    if (has_u2) push_leaf(tags[K_SUBUID], lens[K_SUBUID], forms[K_SUBUID]);
    if (has_u3) push_leaf(tags[K_EXTS], lens[K_EXTS], forms[K_EXTS]);
    push_leaf(tags[K_SIGALG], lens[K_SIGALG], forms[K_SIGALG]);
    push_leaf(tags[K_SIGVAL], lens[K_SIGVAL], forms[K_SIGVAL]);

    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        if (feed_q.size() > start + 1) void'(feed_q.pop_back());
      end
    end
    useful += feed_q.size() - start;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) push_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      if (i == 0) push_byte($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
      else push_byte($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
    end
    useful += n;
  endtask

  function automatic int tx_gap();
    int r;
    if (tx_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_feed();
    logic [8:0] entry;
    int         gap;
    while (feed_q.size() != 0) begin
      entry = feed_q.pop_front();
      gap   = tx_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid   <= 1'b1;
      first      <= entry[8];
      byte_value <= entry[7:0];
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin : receiver
    out_ready <= 1'b0;
    rx_run  = 0;
    rx_drop = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_run == 0) begin
        rx_run = $urandom_range(10, 80);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: rx_drop = 0;
          8, 9, 10, 11, 12, 13:   rx_drop = 25;
          14, 15, 16:             rx_drop = 70;
          default: begin
            rx_drop = 100;
            rx_run  = $urandom_range(5, 40);
          end
        endcase
      end
      rx_run--;
      out_ready <= ($urandom_range(0, 99) >= rx_drop);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    byte_value <= 8'h00;
    first      <= 1'b0;
    hold_req    = 1'b0;
    tx_mode     = 1;
    useful      = 0;
    round_no    = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // certificate straight out of reset, no restart flag
    push_byte(1'b0, 8'h30);
    push_byte(1'b0, 8'h82);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'h10);
    // empty TBS through the zero-count long form
    push_byte(1'b0, 8'h30);
    push_byte(1'b0, 8'h80);
    // version wrapper, then version with one value byte
    push_byte(1'b0, TAG_CTX0);
    push_byte(1'b0, 8'h03);
    push_byte(1'b0, 8'h02);
    push_byte(1'b0, 8'h01);
    push_byte(1'b0, 8'hFF);
    // serial with ignored bits set in the long-form count
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hF1);
    push_byte(1'b0, 8'h00);
    // length accumulator overflows, then a dropped byte
    push_byte(1'b1, 8'h30);
    push_byte(1'b0, 8'h83);
    push_byte(1'b0, 8'h01);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'h55);
    // value would end past the last offset
    push_byte(1'b1, 8'h30);
    push_byte(1'b0, 8'h82);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'hFF);
    send_feed();
    drain();

    useful = 0;
    while (useful < ITEM_TARGET) begin
      tx_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      if (round_no == 2) begin
        tx_mode  = 0;
        hold_req = 1'b1;
        build_cert();
      end else if ($urandom_range(0, 9) < 7) begin
        build_cert();
      end else begin
        push_noise();
      end
      send_feed();
      if ($urandom_range(0, 4) == 0) drain();
      round_no++;
    end
    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
